// ===== src/aiq_pkg.sv =====
// Shared types and constants for the Q10 affine inverse block.
`timescale 1ns / 1ps

package aiq_pkg;

   localparam int LIN_W   = 16;
   localparam int SHIFT_W = 24;
   localparam int OUT_W   = 32;
   localparam int DIV_W   = 32;
   localparam int LANES   = 4;

   typedef struct packed {
      logic signed [LIN_W-1:0]   lin_a;
      logic signed [LIN_W-1:0]   lin_b;
      logic signed [LIN_W-1:0]   lin_c;
      logic signed [LIN_W-1:0]   lin_d;
      logic signed [SHIFT_W-1:0] shift_x;
      logic signed [SHIFT_W-1:0] shift_y;
   } aiq_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] inv_a;
      logic signed [OUT_W-1:0] inv_b;
      logic signed [OUT_W-1:0] inv_c;
      logic signed [OUT_W-1:0] inv_d;
      logic signed [OUT_W-1:0] inv_shift_x;
      logic signed [OUT_W-1:0] inv_shift_y;
      logic                    singular;
      logic                    saturated;
   } aiq_rsp_type;

endpackage

// ===== src/affine_inverse_q10.sv =====
// Pipelined fixed-point inverse of a 2x3 affine matrix.
//
// Usage:
//   req_valid/req_stall/req_word carry one matrix word; it is taken at an edge
//   with req_valid high and req_stall low. rsp_valid/rsp_stall/rsp_word return
//   one inverse word per matrix, in order, with singular and saturated flags.
//   The pipeline holds two setup stages, one stage per quotient bit of
//   the four parallel restoring dividers (16 + 2*FRAC_BITS of them), then
//   clamp, multiply and sum stages, and the output register, which also
//   rounds and clamps. Throughput is one word per cycle while rsp_stall
//   does not hold the output; the quotient width sets the depth.
//   Reset clears every valid bit; the pipeline holds no other state.
//   When rsp_stall holds a valid output word, every stage holds and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
//   Bubbles in the pipeline do not block input while the output is free.
`timescale 1ns / 1ps

module affine_inverse_q10 #(
   parameter int FRAC_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  aiq_pkg::aiq_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output aiq_pkg::aiq_rsp_type rsp_word
);
   import aiq_pkg::*;

   localparam int NUM_W  = LIN_W + 2 * FRAC_BITS;
   localparam int EXT_W  = (NUM_W + 1 > OUT_W + 1) ? NUM_W + 1 : OUT_W + 1;
   localparam int PROD_W = SHIFT_W + OUT_W;
   localparam int SUM_W  = PROD_W + 2;

   localparam logic signed [EXT_W-1:0] C_HI = EXT_W'(64'sd2147483647);
   localparam logic signed [EXT_W-1:0] C_LO = -C_HI - EXT_W'(64'sd1);
   localparam logic signed [SUM_W-1:0] S_HI = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] S_LO = -S_HI - SUM_W'(64'sd1);
   localparam logic signed [SUM_W-1:0] ROUND_ADD =
      SUM_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);

   logic advance;

   // stage A
   logic                      a_valid_ff;
   aiq_req_type               a_word_ff;
   logic signed [2*LIN_W-1:0] ad_ff, bc_ff;

   // divider stages
   logic                    vld_ff  [0:NUM_W];
   logic                    sing_ff [0:NUM_W];
   logic signed [SHIFT_W-1:0] sx_ff [0:NUM_W];
   logic signed [SHIFT_W-1:0] sy_ff [0:NUM_W];
   logic [DIV_W-1:0] rem_ff [0:NUM_W][0:LANES-1];
   logic [NUM_W-1:0] num_ff [0:NUM_W][0:LANES-1];
   logic [NUM_W-1:0] quo_ff [0:NUM_W][0:LANES-1];
   logic [DIV_W-1:0] dvs_ff [0:NUM_W][0:LANES-1];
   logic             neg_ff [0:NUM_W][0:LANES-1];

   logic [NUM_W-1:0] num0_in [0:LANES-1];
   logic [DIV_W-1:0] dvs0_in [0:LANES-1];
   logic             neg0_in [0:LANES-1];
   logic             sing0_in;

   // clamp stage
   logic                    c_valid_ff, c_sing_ff, c_sat_ff;
   logic signed [OUT_W-1:0] r_ff [0:LANES-1];
   logic signed [OUT_W-1:0] r_in [0:LANES-1];
   logic                    c_sat_in;
   logic signed [SHIFT_W-1:0] c_sx_ff, c_sy_ff;

   // product stage
   logic                     d_valid_ff, d_sing_ff, d_sat_ff;
   logic signed [OUT_W-1:0]  d_r_ff [0:LANES-1];
   logic signed [PROD_W-1:0] p_ff [0:LANES-1];

   // sum stage
   logic                     e_valid_ff, e_sing_ff, e_sat_ff;
   logic signed [OUT_W-1:0]  e_r_ff [0:LANES-1];
   logic signed [SUM_W-1:0]  nx_ff, ny_ff;

   // output stage
   logic        rsp_valid_ff;
   aiq_rsp_type rsp_word_ff;
   aiq_rsp_type rsp_word_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
      if (advance) begin
         a_word_ff <= req_word;
         ad_ff     <= req_word.lin_a * req_word.lin_d;
         bc_ff     <= req_word.lin_b * req_word.lin_c;
      end
   end

   always_comb begin
      logic signed [DIV_W:0]  det;
      logic signed [LIN_W:0]  base [0:LANES-1];
      logic signed [DIV_W:0]  dsig [0:LANES-1];
      logic signed [LIN_W:0]  bmag;
      logic signed [DIV_W:0]  dmag;
      logic                   is_scale, is_rot;
      det      = (DIV_W+1)'(ad_ff) - (DIV_W+1)'(bc_ff);
      is_scale = (a_word_ff.lin_b == '0) && (a_word_ff.lin_c == '0);
      is_rot   = !is_scale && (a_word_ff.lin_a == '0) && (a_word_ff.lin_d == '0);
      for (int l = 0; l < LANES; l++) begin
         base[l] = '0;
         dsig[l] = (DIV_W+1)'(1);
      end
      if (is_scale) begin
         base[0] = (LIN_W+1)'(1);
         dsig[0] = (DIV_W+1)'(a_word_ff.lin_a);
         base[3] = (LIN_W+1)'(1);
         dsig[3] = (DIV_W+1)'(a_word_ff.lin_d);
         sing0_in = (a_word_ff.lin_a == '0) || (a_word_ff.lin_d == '0);
      end else if (is_rot) begin
         base[1] = (LIN_W+1)'(1);
         dsig[1] = (DIV_W+1)'(a_word_ff.lin_c);
         base[2] = (LIN_W+1)'(1);
         dsig[2] = (DIV_W+1)'(a_word_ff.lin_b);
         sing0_in = (a_word_ff.lin_b == '0) || (a_word_ff.lin_c == '0);
      end else begin
         base[0] = (LIN_W+1)'(a_word_ff.lin_d);
         base[1] = -((LIN_W+1)'(a_word_ff.lin_b));
         base[2] = -((LIN_W+1)'(a_word_ff.lin_c));
         base[3] = (LIN_W+1)'(a_word_ff.lin_a);
         for (int l = 0; l < LANES; l++) begin
            dsig[l] = det;
         end
         sing0_in = (det == '0);
      end
      for (int l = 0; l < LANES; l++) begin
         bmag = base[l][LIN_W] ? -base[l] : base[l];
         dmag = dsig[l][DIV_W] ? -dsig[l] : dsig[l];
         num0_in[l] = NUM_W'(bmag[LIN_W-1:0]) << (2 * FRAC_BITS);
         dvs0_in[l] = (dmag[DIV_W-1:0] == '0) ? DIV_W'(1) : dmag[DIV_W-1:0];
         neg0_in[l] = base[l][LIN_W] ^ dsig[l][DIV_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= a_valid_ff;
      end
      if (advance) begin
         sing_ff[0] <= sing0_in;
         sx_ff[0]   <= a_word_ff.shift_x;
         sy_ff[0]   <= a_word_ff.shift_y;
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= '0;
            num_ff[0][l] <= num0_in[l];
            quo_ff[0][l] <= '0;
            dvs_ff[0][l] <= dvs0_in[l];
            neg_ff[0][l] <= neg0_in[l];
         end
      end
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_div
      logic [DIV_W-1:0] rem_in [0:LANES-1];
      logic [NUM_W-1:0] quo_in [0:LANES-1];

      always_comb begin
         logic [DIV_W:0] trial;
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_ff[s][l], num_ff[s][l][NUM_W-1]};
            if (trial >= {1'b0, dvs_ff[s][l]}) begin
               rem_in[l] = DIV_W'(trial - {1'b0, dvs_ff[s][l]});
               quo_in[l] = {quo_ff[s][l][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[DIV_W-1:0];
               quo_in[l] = {quo_ff[s][l][NUM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (advance) begin
            sing_ff[s+1] <= sing_ff[s];
            sx_ff[s+1]   <= sx_ff[s];
            sy_ff[s+1]   <= sy_ff[s];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s+1][l] <= rem_in[l];
               num_ff[s+1][l] <= {num_ff[s][l][NUM_W-2:0], 1'b0};
               quo_ff[s+1][l] <= quo_in[l];
               dvs_ff[s+1][l] <= dvs_ff[s][l];
               neg_ff[s+1][l] <= neg_ff[s][l];
            end
         end
      end
   end

   always_comb begin
      logic signed [EXT_W-1:0] qv;
      c_sat_in = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         qv = signed'(EXT_W'(quo_ff[NUM_W][l]));
         if (neg_ff[NUM_W][l]) begin
            qv = -qv;
         end
         if (qv > C_HI) begin
            r_in[l]  = OUT_W'(C_HI);
            c_sat_in = 1'b1;
         end else if (qv < C_LO) begin
            r_in[l]  = OUT_W'(C_LO);
            c_sat_in = 1'b1;
         end else begin
            r_in[l] = qv[OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= vld_ff[NUM_W];
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
      if (advance) begin
         c_sing_ff <= sing_ff[NUM_W];
         c_sat_ff  <= c_sat_in;
         c_sx_ff   <= sx_ff[NUM_W];
         c_sy_ff   <= sy_ff[NUM_W];
         for (int l = 0; l < LANES; l++) begin
            r_ff[l]   <= r_in[l];
            d_r_ff[l] <= r_ff[l];
            e_r_ff[l] <= d_r_ff[l];
         end
         d_sing_ff <= c_sing_ff;
         d_sat_ff  <= c_sat_ff;
         p_ff[0]   <= c_sx_ff * r_ff[0];
         p_ff[1]   <= c_sx_ff * r_ff[1];
         p_ff[2]   <= c_sy_ff * r_ff[2];
         p_ff[3]   <= c_sy_ff * r_ff[3];
         e_sing_ff <= d_sing_ff;
         e_sat_ff  <= d_sat_ff;
         nx_ff     <= -(SUM_W'(p_ff[0]) + SUM_W'(p_ff[2]));
         ny_ff     <= -(SUM_W'(p_ff[1]) + SUM_W'(p_ff[3]));
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] rx, ry;
      logic                    sat;
      rx  = (nx_ff[SUM_W-1] ? nx_ff + ROUND_ADD : nx_ff) >>> FRAC_BITS;
      ry  = (ny_ff[SUM_W-1] ? ny_ff + ROUND_ADD : ny_ff) >>> FRAC_BITS;
      sat = e_sat_ff;
      rsp_word_in.inv_a = e_r_ff[0];
      rsp_word_in.inv_b = e_r_ff[1];
      rsp_word_in.inv_c = e_r_ff[2];
      rsp_word_in.inv_d = e_r_ff[3];
      if (rx > S_HI) begin
         rsp_word_in.inv_shift_x = OUT_W'(S_HI);
         sat = 1'b1;
      end else if (rx < S_LO) begin
         rsp_word_in.inv_shift_x = OUT_W'(S_LO);
         sat = 1'b1;
      end else begin
         rsp_word_in.inv_shift_x = rx[OUT_W-1:0];
      end
      if (ry > S_HI) begin
         rsp_word_in.inv_shift_y = OUT_W'(S_HI);
         sat = 1'b1;
      end else if (ry < S_LO) begin
         rsp_word_in.inv_shift_y = OUT_W'(S_LO);
         sat = 1'b1;
      end else begin
         rsp_word_in.inv_shift_y = ry[OUT_W-1:0];
      end
      rsp_word_in.singular  = e_sing_ff;
      rsp_word_in.saturated = sat;
      if (e_sing_ff) begin
         rsp_word_in             = '0;
         rsp_word_in.singular    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= e_valid_ff;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
